// File: rtl/crc8wd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the checked word deframer.
package crc8wd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_TOP  = 8'h80;
  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_CHECK = 2'd2
  } phase_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP) != 8'd0) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// File: rtl/crc8_checked_word_deframer.sv
// Top level: frames received bytes into CRC-8 checked 16-bit words.
//
// Input channel (in_valid/in_ready): one received byte per transfer, with
// in_start_of_read marking the first byte of a read and in_last_of_read the
// final one. Bytes group in threes: high data byte, low data byte, check byte.
// A start flag drops any partial group and clears the sticky error flag.
// A last flag on a data byte drops the partial group.
//
// Output channel (out_valid/out_ready): one transfer per check byte carrying
// the big-endian word, crc_ok, the sticky read_ok and last_word.
//
// A result appears in the cycle after its check byte is accepted.
// Throughput: one byte per cycle unless stalled; the CRC byte update is a
// single unrolled eight-step XOR network between the framing registers.
// The result register is a single stage: in_ready is low only while a result
// is held and out_ready is low, so a stalled receiver stalls the input.
// Reset (rst_n low, synchronous) returns framing to the high byte, sets the
// running CRC to 0xFF, clears the error flag and empties the result register.
module crc8_checked_word_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_start_of_read,
  input  logic        in_last_of_read,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data_word,
  output logic        out_crc_ok,
  output logic        out_read_ok,
  output logic        out_last_word
);

  crc8wd_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [7:0]  crc_r, crc_nxt, crc_base;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        err_r, err_nxt, err_base;
  logic        emit;
  logic        ok;
  logic        accept;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_word_r;
  logic        out_crc_ok_r, out_read_ok_r, out_last_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign phase_eff = in_start_of_read ? crc8wd_pkg::PH_HIGH : phase_r;
  assign crc_base  = in_start_of_read ? crc8wd_pkg::CRC_INIT : crc_r;
  assign err_base  = in_start_of_read ? 1'b0 : err_r;

  // next framing state
  always_comb begin
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    err_nxt   = err_base;
    case (phase_eff)
      crc8wd_pkg::PH_LOW: begin
        low_nxt   = in_rx_byte;
        crc_nxt   = crc8wd_pkg::crc8_byte(crc_base, in_rx_byte);
        phase_nxt = crc8wd_pkg::PH_CHECK;
      end
      crc8wd_pkg::PH_CHECK: begin
        err_nxt   = err_base | (in_rx_byte != crc_base);
        crc_nxt   = crc8wd_pkg::CRC_INIT;
        phase_nxt = crc8wd_pkg::PH_HIGH;
      end
      default: begin
        high_nxt  = in_rx_byte;
        crc_nxt   = crc8wd_pkg::crc8_byte(crc8wd_pkg::CRC_INIT, in_rx_byte);
        phase_nxt = crc8wd_pkg::PH_LOW;
      end
    endcase
    if (in_last_of_read) begin
      crc_nxt   = crc8wd_pkg::CRC_INIT;
      phase_nxt = crc8wd_pkg::PH_HIGH;
    end
  end

  // result decode
  always_comb begin
    emit = 1'b0;
    ok   = 1'b0;
    case (phase_eff)
      crc8wd_pkg::PH_CHECK: begin
        emit = 1'b1;
        ok   = (in_rx_byte == crc_base);
      end
      default: begin
        emit = 1'b0;
        ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= crc8wd_pkg::PH_HIGH;
      crc_r       <= crc8wd_pkg::CRC_INIT;
      high_r      <= 8'd0;
      low_r       <= 8'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        crc_r   <= crc_nxt;
        high_r  <= high_nxt;
        low_r   <= low_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_word_r    <= {high_r, low_r};
      out_crc_ok_r  <= ok;
      out_read_ok_r <= !err_nxt;
      out_last_r    <= in_last_of_read;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_word = out_word_r;
  assign out_crc_ok    = out_crc_ok_r;
  assign out_read_ok   = out_read_ok_r;
  assign out_last_word = out_last_r;

endmodule

// File: rtl/crc8wd_checker.sv
// Port-level checker for the checked word deframer, with its bind.
module crc8wd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_data_word,
  input logic        out_crc_ok,
  input logic        out_read_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_word))
    else $error("result word changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty result register");

  a_read_ok_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_ok |-> out_crc_ok)
    else $error("read_ok set on a word with a CRC mismatch");

endmodule

bind crc8_checked_word_deframer crc8wd_checker u_crc8wd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_data_word (out_data_word),
  .out_crc_ok    (out_crc_ok),
  .out_read_ok   (out_read_ok)
);
